// ----- hw/rtl/ultrasonic_echo_ranger_core_assert.svh -----
// Assertion macros used by the checker file of the echo ranger.
`ifndef ULTRASONIC_ECHO_RANGER_CORE_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_ASSERT_SVH

// Same-cycle implication, gated by reset.
`define UER_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("echo ranger check failed");

// Next-cycle implication, gated by reset.
`define UER_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("echo ranger check failed");

`endif

// ----- hw/rtl/uer_pkg.sv -----
// ---------------------------------------------------------------------------
// uer_pkg
// Types and constants shared by the echo ranger modules.
// ---------------------------------------------------------------------------
package uer_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_NEAR_LIMIT = 2'd0;
  localparam logic [1:0] REG_TRIGGER    = 2'd1;
  localparam logic [1:0] REG_REPEAT     = 2'd2;

  localparam int CFG_DATA_W = 22;
  localparam int DIST_W     = 11;
  localparam int TICK_W     = 22;
  localparam int TRIG_W     = 8;

  localparam logic [DIST_W-1:0] NEAR_LIMIT_RST = 11'd150;
  localparam logic [TRIG_W-1:0] TRIGGER_RST    = 8'd10;
  localparam logic [TICK_W-1:0] REPEAT_RST     = 22'd1843318;

  // Tick length in ns: time_us = count * 1085 / 1000
  localparam logic [10:0] TICK_NS = 11'd1085;
  // count*1085 at or above this gives time above 65535 us
  localparam logic [35:0] SAT_PRODUCT = 36'd65536000;
  // distance for a saturated time: 65535 / 58
  localparam logic [DIST_W-1:0] DIST_MAX = 11'd1129;
  // floor(q / 3625) = (q * RECIP) >> RECIP_SHIFT for any 22-bit q
  localparam int QUO_W       = 22;
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 34;
  localparam logic [RECIP_W-1:0] RECIP = 23'd4739275;

  // Control bits of one queued word
  typedef struct packed {
    logic trig;
    logic done;
  } uer_ctl_t;

endpackage

// ----- hw/rtl/uer_front.sv -----
// ---------------------------------------------------------------------------
// uer_front
// Measurement sequencer: walks trigger, wait, count and idle phases, one
// tick per accepted word, and hands a control word to the queue.
// ---------------------------------------------------------------------------
module uer_front
  import uer_pkg::*;
#(
  parameter int ECHO_COUNTER_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_echo,
  input  logic [TRIG_W-1:0]            trigger_ticks,
  input  logic [TICK_W-1:0]            repeat_ticks,
  output logic                         q_valid,
  input  logic                         q_ready,
  output uer_ctl_t                     q_ctl,
  output logic [ECHO_COUNTER_BITS-1:0] q_count
);

  typedef enum logic [1:0] {
    PH_TRIGGER,
    PH_WAIT,
    PH_COUNT,
    PH_IDLE
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [TICK_W-1:0]            tick_r, tick_nxt;
  logic [ECHO_COUNTER_BITS-1:0] echo_cnt_r, echo_cnt_nxt;
  logic [TICK_W-1:0]            tick_inc;
  logic [ECHO_COUNTER_BITS-1:0] echo_inc;
  logic [TRIG_W-1:0]            trig_len;
  logic                         fire;

  assign q_valid  = in_valid;
  assign in_ready = q_ready;
  assign fire     = in_valid && q_ready;

  assign tick_inc = tick_r + TICK_W'(1);
  assign echo_inc = echo_cnt_r + ECHO_COUNTER_BITS'(1);
  assign trig_len = (trigger_ticks == '0) ? TRIG_W'(1) : trigger_ticks;

  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    echo_cnt_nxt = echo_cnt_r;
    q_ctl        = '0;
    q_count      = '0;
    unique case (phase_r)
      PH_TRIGGER: begin
        q_ctl.trig = 1'b1;
        if (tick_inc >= TICK_W'(trig_len)) begin
          tick_nxt  = '0;
          phase_nxt = PH_WAIT;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      PH_WAIT: begin
        if (in_echo) begin
          echo_cnt_nxt = ECHO_COUNTER_BITS'(1);
          phase_nxt    = PH_COUNT;
        end
      end
      PH_COUNT: begin
        // overflow or falling echo ends the measurement
        if (!in_echo || echo_inc == '0) begin
          q_ctl.done = 1'b1;
          q_count    = in_echo ? '0 : echo_cnt_r;
          tick_nxt   = '0;
          phase_nxt  = (repeat_ticks == '0) ? PH_TRIGGER : PH_IDLE;
        end
        echo_cnt_nxt = echo_inc;
      end
      PH_IDLE: begin
        if (tick_inc >= repeat_ticks) begin
          tick_nxt  = '0;
          phase_nxt = PH_TRIGGER;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      default: phase_nxt = PH_TRIGGER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TRIGGER;
      tick_r     <= '0;
      echo_cnt_r <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      echo_cnt_r <= echo_cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/uer_fifo.sv -----
// ---------------------------------------------------------------------------
// uer_fifo
// Small word queue between the sequencer and the distance pipeline.
// ---------------------------------------------------------------------------
module uer_fifo #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             push, pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/uer_back.sv -----
// ---------------------------------------------------------------------------
// uer_back
// Distance pipeline: count to centimetres, near/far flags, held result and
// output register.
// ---------------------------------------------------------------------------
module uer_back
  import uer_pkg::*;
#(
  parameter int ECHO_COUNTER_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  uer_ctl_t                     q_ctl,
  input  logic [ECHO_COUNTER_BITS-1:0] q_count,
  input  logic [DIST_W-1:0]            near_limit_cm,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_trigger,
  output logic                         out_done_res,
  output logic [DIST_W-1:0]            out_distance_cm,
  output logic                         out_near,
  output logic                         out_far
);

  localparam int PW = ECHO_COUNTER_BITS + 11;
  localparam int PROD_W = QUO_W + RECIP_W;

  logic                advance;
  // stage A: count * 1085
  logic                a_v_r;
  uer_ctl_t            a_ctl_r;
  logic [PW-1:0]       a_p_r;
  // stage B: reciprocal product for / 58000
  logic                b_v_r;
  uer_ctl_t            b_ctl_r;
  logic                b_sat_r;
  logic [PROD_W-1:0]   b_prod_r;
  logic [35:0]         a_p_ext;
  logic [QUO_W-1:0]    a_q;
  // held result
  logic [DIST_W-1:0]   held_dist_r;
  logic                held_near_r, held_far_r;
  logic [DIST_W-1:0]   dist_new;
  logic                near_new;
  // output register
  logic                out_v_r;
  uer_ctl_t            out_ctl_r;
  logic [DIST_W-1:0]   out_dist_r;
  logic                out_near_r, out_far_r;

  assign advance = !out_v_r || out_ready;
  assign q_ready = advance;

  assign a_p_ext = 36'(a_p_r);
  assign a_q     = a_p_ext[QUO_W+3:4];

  assign dist_new = b_sat_r ? DIST_MAX : b_prod_r[RECIP_SHIFT+DIST_W-1:RECIP_SHIFT];
  assign near_new = (dist_new != '0) && (dist_new <= near_limit_cm);

  always_ff @(posedge clk) begin
    if (advance) begin
      a_ctl_r  <= q_ctl;
      a_p_r    <= PW'(q_count) * PW'(TICK_NS);
      b_ctl_r  <= a_ctl_r;
      b_sat_r  <= (a_p_ext >= SAT_PRODUCT);
      b_prod_r <= PROD_W'(a_q) * PROD_W'(RECIP);
      out_ctl_r <= b_ctl_r;
      if (b_ctl_r.done) begin
        out_dist_r <= dist_new;
        out_near_r <= near_new;
        out_far_r  <= !near_new;
      end else begin
        out_dist_r <= held_dist_r;
        out_near_r <= held_near_r;
        out_far_r  <= held_far_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      out_v_r     <= 1'b0;
      held_dist_r <= '0;
      held_near_r <= 1'b0;
      held_far_r  <= 1'b0;
    end else if (advance) begin
      a_v_r   <= q_valid;
      b_v_r   <= a_v_r;
      out_v_r <= b_v_r;
      if (b_v_r && b_ctl_r.done) begin
        held_dist_r <= dist_new;
        held_near_r <= near_new;
        held_far_r  <= !near_new;
      end
    end
  end

  assign out_valid       = out_v_r;
  assign out_trigger     = out_ctl_r.trig;
  assign out_done_res    = out_ctl_r.done;
  assign out_distance_cm = out_dist_r;
  assign out_near        = out_near_r;
  assign out_far         = out_far_r;

endmodule

// ----- hw/rtl/ultrasonic_echo_ranger_core.sv -----
// ---------------------------------------------------------------------------
// ultrasonic_echo_ranger_core
// Time-of-flight ranger driven by timer ticks: trigger, echo timing,
// distance in centimetres and near/far flags, one result word per tick.
// ---------------------------------------------------------------------------
// Each input word is one timer tick carrying the sampled echo level, and it
// yields exactly one result word with the trigger level for that tick, a
// done strobe on the tick a measurement ends, and the held distance and
// near/far flags. The block takes one tick per clock cycle while the
// output side is not stalled: the sequencer closes its phase and counter
// update on each accepted tick, and the distance math runs in a three-stage
// pipeline (a multiply in each of the first two stages, the flag compare in
// the output register) behind a four-word queue. A tick's result passes
// through the queue and then the stage A, stage B and output registers.
// Write the configuration registers only while no ticks are in flight.
// ---------------------------------------------------------------------------
module ultrasonic_echo_ranger_core
  import uer_pkg::*;
#(
  parameter int ECHO_COUNTER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // tick input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_echo,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_trigger,
  output logic                  out_done_res,
  output logic [DIST_W-1:0]     out_distance_cm,
  output logic                  out_near,
  output logic                  out_far
);

  localparam int QW = $bits(uer_ctl_t) + ECHO_COUNTER_BITS;

  logic [DIST_W-1:0] near_limit_r;
  logic [TRIG_W-1:0] trigger_ticks_r;
  logic [TICK_W-1:0] repeat_ticks_r;

  // Register file: an index past the list drops the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_limit_r    <= NEAR_LIMIT_RST;
      trigger_ticks_r <= TRIGGER_RST;
      repeat_ticks_r  <= REPEAT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_NEAR_LIMIT: near_limit_r    <= cfg_wdata[DIST_W-1:0];
        REG_TRIGGER:    trigger_ticks_r <= cfg_wdata[TRIG_W-1:0];
        REG_REPEAT:     repeat_ticks_r  <= cfg_wdata[TICK_W-1:0];
        default:        ;
      endcase
    end
  end

  // Sequencer to queue
  logic                         fq_valid, fq_ready;
  uer_ctl_t                     fq_ctl;
  logic [ECHO_COUNTER_BITS-1:0] fq_count;
  // Queue to distance pipeline
  logic                         qb_valid, qb_ready;
  logic [QW-1:0]                qb_data;
  uer_ctl_t                     qb_ctl;
  logic [ECHO_COUNTER_BITS-1:0] qb_count;

  uer_front #(
    .ECHO_COUNTER_BITS(ECHO_COUNTER_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_echo       (in_echo),
    .trigger_ticks (trigger_ticks_r),
    .repeat_ticks  (repeat_ticks_r),
    .q_valid       (fq_valid),
    .q_ready       (fq_ready),
    .q_ctl         (fq_ctl),
    .q_count       (fq_count)
  );

  uer_fifo #(
    .WIDTH(QW),
    .DEPTH(4)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  ({fq_ctl, fq_count}),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // Split the queued word back into control and count.
  assign qb_ctl   = qb_data[QW-1:ECHO_COUNTER_BITS];
  assign qb_count = qb_data[ECHO_COUNTER_BITS-1:0];

  uer_back #(
    .ECHO_COUNTER_BITS(ECHO_COUNTER_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (qb_valid),
    .q_ready         (qb_ready),
    .q_ctl           (qb_ctl),
    .q_count         (qb_count),
    .near_limit_cm   (near_limit_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_trigger     (out_trigger),
    .out_done_res    (out_done_res),
    .out_distance_cm (out_distance_cm),
    .out_near        (out_near),
    .out_far         (out_far)
  );

endmodule

// ----- hw/rtl/uer_checker.sv -----
// ---------------------------------------------------------------------------
// uer_checker
// Port-level checks on the echo ranger result stream, bound to the top.
// ---------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_core_assert.svh"

module uer_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_trigger,
  input logic        out_done_res,
  input logic [10:0] out_distance_cm,
  input logic        out_near,
  input logic        out_far
);

  // hold a stalled word
  `UER_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `UER_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_distance_cm))
  // near and far never both set
  `UER_ASSERT_IMPL(a_flags_excl, out_valid, !(out_near && out_far))
  // near needs a nonzero distance
  `UER_ASSERT_IMPL(a_near_dist, out_valid && out_near, out_distance_cm != 11'd0)
  // a measurement never ends on a trigger tick, and always sets a flag
  `UER_ASSERT_IMPL(a_done_flags, out_valid && out_done_res,
                   !out_trigger && (out_near != out_far))

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (.*);
